### src/mspsc_pkg.sv
// ----------------------------------------------------------------------------
// Motor and servo setpoint controller package
// Shared job type, status codes and action codes.
// ----------------------------------------------------------------------------
package mspsc_pkg;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_ENABLE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_NO_DEVICE = 2'd2;

  localparam logic KIND_MOTOR = 1'b0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [16:0] ONE_Q14      = 17'sd16384;
  localparam logic [25:0]        SERVO_OFFSET = 26'd20127744;
  localparam logic [11:0]        SERVO_GAIN   = 12'd2457;
  localparam logic [3:0]         MOTOR_CH_BASE = 4'd4;
  localparam logic [3:0]         SERVO_CH_HIGH = 4'd8;

  typedef enum logic [1:0] {
    JOB_MOTOR,
    JOB_SERVO,
    JOB_BAD,
    JOB_NODEV
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [3:0]         chan;
    logic signed [15:0] value;
    logic               enabled;
  } job_t;

endpackage

### src/mspsc_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands, updates setpoints and enable bits, and issues one job per
// command that produces results.
// ----------------------------------------------------------------------------
module mspsc_front
  import mspsc_pkg::*;
#(
  parameter int MOTOR_COUNT = 4,
  parameter int SERVO_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic               target_kind,
  input  logic [3:0]         unit_index,
  input  logic signed [15:0] amount,
  input  logic               enable_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               queue_full,
  output logic               job_push,
  output job_t               job
);

  localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int SIDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  logic signed [15:0] motor_speed [MOTOR_COUNT];
  logic [14:0]        servo_position [SERVO_COUNT];
  logic [MOTOR_COUNT-1:0] motor_enabled;
  logic [SERVO_COUNT-1:0] servo_enabled;
  logic               pwm_present;

  logic [MIDX_W-1:0]  mi;
  logic [SIDX_W-1:0]  si;
  logic               is_motor;
  logic               bad;
  logic               accept;
  logic               update;
  logic signed [16:0] cur;
  logic signed [16:0] sum;
  logic signed [16:0] lo;
  logic signed [16:0] clamped;
  logic               cur_en;
  logic               new_en;
  logic [3:0]         chan;

  assign cfg_ready = 1'b1;
  assign full      = queue_full;
  assign accept    = push && !full && (action != ACT_NONE);
  assign is_motor  = (target_kind == KIND_MOTOR);
  assign mi        = unit_index[MIDX_W-1:0];
  assign si        = unit_index[SIDX_W-1:0];
  assign bad       = is_motor ? (unit_index >= 4'(MOTOR_COUNT))
                              : (unit_index >= 4'(SERVO_COUNT));
  assign update    = accept && !bad;

  always_comb begin
    if (is_motor) begin
      cur    = {motor_speed[mi][15], motor_speed[mi]};
      cur_en = motor_enabled[mi];
      lo     = -ONE_Q14;
      chan   = MOTOR_CH_BASE + {unit_index[2:0], 1'b0};
    end else begin
      cur    = {2'b00, servo_position[si]};
      cur_en = servo_enabled[si];
      lo     = 17'sd0;
      chan   = unit_index[2] ? (unit_index + SERVO_CH_HIGH) : unit_index;
    end
    case (action)
      ACT_SET:    sum = {amount[15], amount};
      ACT_ADD:    sum = cur + {amount[15], amount};
      default:    sum = cur;
    endcase
    if (sum < lo) begin
      clamped = lo;
    end else if (sum > ONE_Q14) begin
      clamped = ONE_Q14;
    end else begin
      clamped = sum;
    end
    new_en = (action == ACT_ENABLE) ? enable_flag : cur_en;
  end

  always_comb begin
    job_push    = accept;
    job.chan    = chan;
    job.value   = clamped[15:0];
    job.enabled = new_en;
    if (bad) begin
      job.kind = JOB_BAD;
    end else if (!pwm_present) begin
      job.kind = JOB_NODEV;
    end else if (is_motor) begin
      job.kind = JOB_MOTOR;
    end else begin
      job.kind = JOB_SERVO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_present   <= 1'b0;
      motor_enabled <= '0;
      servo_enabled <= '0;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        motor_speed[k] <= '0;
      end
      for (int k = 0; k < SERVO_COUNT; k++) begin
        servo_position[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        pwm_present <= cfg_data;
      end
      if (update) begin
        if (is_motor) begin
          motor_speed[mi]   <= clamped[15:0];
          motor_enabled[mi] <= new_en;
        end else begin
          servo_position[si] <= clamped[14:0];
          servo_enabled[si]  <= new_en;
        end
      end
    end
  end

endmodule

### src/mspsc_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out queue between the front end and the write stage.
// ----------------------------------------------------------------------------
module mspsc_queue
  import mspsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd_en,
  output job_t rd_job,
  output logic rd_valid
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign q_full   = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/mspsc_back.sv
// ----------------------------------------------------------------------------
// Channel write stage
// Turns each job into its channel writes and holds them in the result
// register until they are taken.
// ----------------------------------------------------------------------------
module mspsc_back
  import mspsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        job,
  input  logic        job_valid,
  output logic        job_pop,
  input  logic        pop,
  output logic        empty,
  output logic [3:0]  channel,
  output logic        on_count,
  output logic [11:0] off_count,
  output logic        write_valid,
  output logic [1:0]  status,
  output logic        last
);

  logic        out_valid;
  logic        phase;
  logic        advance;
  logic        neg;
  logic        pos;
  logic [15:0] abs_full;
  logic [14:0] abs_val;
  logic [26:0] prod;
  logic [11:0] mag;
  logic [25:0] servo_sum;
  logic [11:0] ticks;
  logic [3:0]  channel_next;
  logic        on_count_next;
  logic [11:0] off_count_next;
  logic        write_valid_next;
  logic [1:0]  status_next;
  logic        last_next;

  assign empty   = !out_valid;
  assign advance = job_valid && (!out_valid || pop);
  assign job_pop = advance && ((job.kind != JOB_MOTOR) || phase);

  always_comb begin
    neg       = job.value[15];
    pos       = !neg && (job.value != '0);
    abs_full  = neg ? (16'd0 - job.value) : job.value;
    abs_val   = abs_full[14:0];
    prod      = {abs_val, 12'd0} - {12'd0, abs_val};
    mag       = job.enabled ? prod[25:14] : 12'd0;
    servo_sum = SERVO_OFFSET + (26'(job.value[14:0]) * 26'(SERVO_GAIN));
    ticks     = {3'd0, servo_sum[25:17]};

    channel_next     = 4'd0;
    on_count_next    = 1'b0;
    off_count_next   = 12'd0;
    write_valid_next = 1'b0;
    status_next      = ST_OK;
    last_next        = 1'b1;
    case (job.kind)
      JOB_MOTOR: begin
        channel_next     = job.chan + {3'd0, phase};
        write_valid_next = 1'b1;
        last_next        = phase;
        if (phase) begin
          off_count_next = neg ? mag : 12'd0;
        end else begin
          off_count_next = pos ? mag : 12'd0;
        end
      end
      JOB_SERVO: begin
        channel_next     = job.chan;
        write_valid_next = 1'b1;
        on_count_next    = !job.enabled;
        off_count_next   = job.enabled ? ticks : 12'd0;
      end
      JOB_BAD: begin
        status_next = ST_BAD_INDEX;
      end
      default: begin
        status_next = ST_NO_DEVICE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      channel     <= channel_next;
      on_count    <= on_count_next;
      off_count   <= off_count_next;
      write_valid <= write_valid_next;
      status      <= status_next;
      last        <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (advance && (job.kind == JOB_MOTOR)) begin
        phase <= !phase;
      end
    end
  end

endmodule

### src/motor_servo_pwm_setpoint_ctrl_unit.sv
// ----------------------------------------------------------------------------
// Motor and servo setpoint controller
// Keeps setpoints and enable bits for motors and servos and issues the PWM
// channel writes that follow from each command.
// ----------------------------------------------------------------------------
// A command transaction is taken whenever the two-entry job queue has room;
// the front end updates the setpoint and enable bit in that same cycle. The
// write stage delivers one result per cycle unless its result register waits
// for a pop: a motor command produces two channel writes, every other command
// produces one. The first result passes through the job queue and then the
// result register on its way to the result ports, when the result register
// is free. Action code 3 is taken and produces nothing.
module motor_servo_pwm_setpoint_ctrl_unit
  import mspsc_pkg::*;
#(
  parameter int MOTOR_COUNT = 4,
  parameter int SERVO_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic               target_kind,
  input  logic [3:0]         unit_index,
  input  logic signed [15:0] amount,
  input  logic               enable_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         channel,
  output logic               on_count,
  output logic [11:0]        off_count,
  output logic               write_valid,
  output logic [1:0]         status,
  output logic               last
);

  logic queue_full;
  logic job_push;
  job_t front_job;
  job_t head_job;
  logic head_valid;
  logic head_pop;

  mspsc_front #(
    .MOTOR_COUNT(MOTOR_COUNT),
    .SERVO_COUNT(SERVO_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .target_kind (target_kind),
    .unit_index  (unit_index),
    .amount      (amount),
    .enable_flag (enable_flag),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .queue_full  (queue_full),
    .job_push    (job_push),
    .job         (front_job)
  );

  mspsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (front_job),
    .q_full   (queue_full),
    .rd_en    (head_pop),
    .rd_job   (head_job),
    .rd_valid (head_valid)
  );

  mspsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .job_valid   (head_valid),
    .job_pop     (head_pop),
    .pop         (pop),
    .empty       (empty),
    .channel     (channel),
    .on_count    (on_count),
    .off_count   (off_count),
    .write_valid (write_valid),
    .status      (status),
    .last        (last)
  );

endmodule

### tb/motor_servo_pwm_setpoint_ctrl_unit_tb.sv
// ----------------------------------------------------------------------------
// Motor and servo setpoint controller testbench
// A driver feeds command transactions from a queue of pending commands and a
// monitor predicts the PWM channel writes of each accepted command. Every
// popped result is checked against the oldest prediction. The run covers
// directed corner commands, then random commands under several idling
// patterns, with the PWM device both present and absent.
// ----------------------------------------------------------------------------
module motor_servo_pwm_setpoint_ctrl_unit_tb;
  import mspsc_pkg::*;

  localparam int MOTOR_UNITS   = 4;
  localparam int SERVO_UNITS   = 8;
  localparam int FULL_SCALE    = 16384;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic KIND_SERVO  = ~KIND_MOTOR;

  typedef struct packed {
    logic [1:0]         act;
    logic               kind;
    logic [3:0]         idx;
    logic signed [15:0] amt;
    logic               en;
  } command_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic        on;
    logic [11:0] off;
    logic        valid;
    logic [1:0]  status;
    logic        last;
  } pwm_write_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         action = ACT_SET;
  logic               target_kind = KIND_MOTOR;
  logic [3:0]         unit_index = 4'd0;
  logic signed [15:0] amount = 16'sd0;
  logic               enable_flag = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [3:0]         channel;
  logic               on_count;
  logic [11:0]        off_count;
  logic               write_valid;
  logic [1:0]         status;
  logic               last;

  command_t   pending_cmds[$];
  pwm_write_t expected_writes[$];
  command_t   next_cmd;

  int   motor_speed_m [MOTOR_UNITS] = '{default: 0};
  int   servo_pos_m   [SERVO_UNITS] = '{default: 0};
  bit   motor_en_m    [MOTOR_UNITS] = '{default: 1'b0};
  bit   servo_en_m    [SERVO_UNITS] = '{default: 1'b0};
  bit   pwm_present_m = 1'b0;

  int   sender_idle   = 9;
  int   receiver_idle = 52;
  int   n_queued      = 0;
  int   n_accepted    = 0;
  int   n_results     = 0;
  int   errors        = 0;
  int   cycles        = 0;
  logic cmd_taken     = 1'b0;

  motor_servo_pwm_setpoint_ctrl_unit dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .target_kind(target_kind),
    .unit_index (unit_index),
    .amount     (amount),
    .enable_flag(enable_flag),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .channel    (channel),
    .on_count   (on_count),
    .off_count  (off_count),
    .write_valid(write_valid),
    .status     (status),
    .last       (last)
  );

  always #2 clk = ~clk;

  function automatic pwm_write_t make_write(int ch, int on, int off, int valid,
                                            logic [1:0] st, int lst);
    pwm_write_t w;
    w.channel = 4'(ch);
    w.on      = 1'(on);
    w.off     = 12'(off);
    w.valid   = 1'(valid);
    w.status  = st;
    w.last    = 1'(lst);
    return w;
  endfunction

  task automatic expect_write(input pwm_write_t w);
    expected_writes.insert(expected_writes.size(), w);
  endtask

  task automatic predict_writes(input command_t c);
    int s;
    int mag;
    int ticks;
    int ch;
    if (c.act == ACT_NONE) return;
    if (c.kind == KIND_MOTOR) begin
      if (c.idx >= MOTOR_UNITS) begin
        expect_write(make_write(0, 0, 0, 0, ST_BAD_INDEX, 1));
        return;
      end
      case (c.act)
        ACT_SET: s = $signed(c.amt);
        ACT_ADD: s = motor_speed_m[c.idx] + $signed(c.amt);
        default: begin
          motor_en_m[c.idx] = c.en;
          s = motor_speed_m[c.idx];
        end
      endcase
      if (s < -FULL_SCALE) s = -FULL_SCALE;
      if (s > FULL_SCALE) s = FULL_SCALE;
      motor_speed_m[c.idx] = s;
      if (!pwm_present_m) begin
        expect_write(make_write(0, 0, 0, 0, ST_NO_DEVICE, 1));
        return;
      end
      mag = (((s < 0) ? -s : s) * 4095) >>> 14;
      if (!motor_en_m[c.idx]) mag = 0;
      ch = 4 + 2 * c.idx;
      expect_write(make_write(ch, 0, (s > 0) ? mag : 0, 1, ST_OK, 0));
      expect_write(make_write(ch + 1, 0, (s < 0) ? mag : 0, 1, ST_OK, 1));
    end else begin
      if (c.idx >= SERVO_UNITS) begin
        expect_write(make_write(0, 0, 0, 0, ST_BAD_INDEX, 1));
        return;
      end
      case (c.act)
        ACT_SET: s = $signed(c.amt);
        ACT_ADD: s = servo_pos_m[c.idx] + $signed(c.amt);
        default: begin
          servo_en_m[c.idx] = c.en;
          s = servo_pos_m[c.idx];
        end
      endcase
      if (s < 0) s = 0;
      if (s > FULL_SCALE) s = FULL_SCALE;
      servo_pos_m[c.idx] = s;
      if (!pwm_present_m) begin
        expect_write(make_write(0, 0, 0, 0, ST_NO_DEVICE, 1));
        return;
      end
      ch = (c.idx < 4) ? c.idx : c.idx + 8;
      if (servo_en_m[c.idx]) begin
        ticks = (20127744 + 2457 * s) / 131072;
        if (ticks > 4095) ticks = 4095;
        expect_write(make_write(ch, 0, ticks, 1, ST_OK, 1));
      end else begin
        expect_write(make_write(ch, 1, 0, 1, ST_OK, 1));
      end
    end
  endtask

  function automatic command_t random_command();
    command_t c;
    int r;
    r = $urandom_range(99);
    if (r < 5) c.act = ACT_NONE;
    else if (r < 40) c.act = ACT_SET;
    else if (r < 75) c.act = ACT_ADD;
    else c.act = ACT_ENABLE;
    c.kind = 1'($urandom_range(1));
    if ($urandom_range(99) < 88)
      c.idx = 4'((c.kind == KIND_MOTOR) ? $urandom_range(MOTOR_UNITS - 1)
                                        : $urandom_range(SERVO_UNITS - 1));
    else
      c.idx = 4'($urandom_range(15));
    case ($urandom_range(9))
      0:       c.amt = 16'sh7FFF;
      1:       c.amt = 16'sh8000;
      2:       c.amt = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      3, 4, 5: c.amt = $urandom_range(1) ? 16'($urandom_range(4095))
                                         : -16'($urandom_range(4095));
      default: c.amt = 16'($urandom);
    endcase
    c.en = ($urandom_range(99) < 75);
    return c;
  endfunction

  task automatic queue_cmd(input logic [1:0] act, input logic kind, input logic [3:0] idx,
                           input logic signed [15:0] amt, input logic en);
    pending_cmds.insert(pending_cmds.size(), command_t'{act, kind, idx, amt, en});
    n_queued++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_writes.size() != 0);
  endtask

  task automatic write_pwm_present(input logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic start_phase(input bit do_write, input logic value, input int s_idle,
                             input int r_idle);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (do_write) write_pwm_present(value);
    @(posedge clk);
    sender_idle   = s_idle;
    receiver_idle = r_idle;
  endtask

  task automatic run_random(input int n, input bit pause_midway);
    command_t c;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) begin
        wait_quiet();
        @(posedge clk);
      end
      c = random_command();
      queue_cmd(c.act, c.kind, c.idx, c.amt, c.en);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !cmd_taken) begin
      push <= 1'b1;
    end else if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle) begin
      next_cmd    = pending_cmds.pop_front();
      push        <= 1'b1;
      action      <= next_cmd.act;
      target_kind <= next_cmd.kind;
      unit_index  <= next_cmd.idx;
      amount      <= next_cmd.amt;
      enable_flag <= next_cmd.en;
    end else begin
      push <= 1'b0;
    end
  end

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= receiver_idle);
  end

  always @(posedge clk) begin
    pwm_write_t got;
    pwm_write_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= push && !full;
      if (cfg_valid && cfg_ready) pwm_present_m = cfg_data;
      if (push && !full) begin
        n_accepted++;
        predict_writes(command_t'{action, target_kind, unit_index, amount, enable_flag});
      end
      if (pop && !empty) begin
        n_results++;
        got = pwm_write_t'{channel, on_count, off_count, write_valid, status, last};
        if (expected_writes.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected result ch=%0d on=%0d off=%0d valid=%0d st=%0d last=%0d",
                     got.channel, got.on, got.off, got.valid, got.status, got.last);
          errors++;
        end else begin
          want = expected_writes.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("ERROR: mismatch expected ch=%0d on=%0d off=%0d valid=%0d st=%0d last=%0d",
                       want.channel, want.on, want.off, want.valid, want.status, want.last);
              $display("       got ch=%0d on=%0d off=%0d valid=%0d st=%0d last=%0d",
                       got.channel, got.on, got.off, got.valid, got.status, got.last);
            end
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_writes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The register still holds its reset value here, so no device is present.
    start_phase(1'b0, 1'b0, 9, 52);
    queue_cmd(ACT_SET,    KIND_MOTOR, 4'd0,  16'sh1000, 1'b0);
    queue_cmd(ACT_ENABLE, KIND_SERVO, 4'd3,  16'sd0,    1'b1);
    queue_cmd(ACT_ADD,    KIND_MOTOR, 4'd9,  16'sd5,    1'b0);
    queue_cmd(ACT_ADD,    KIND_SERVO, 4'd0,  -16'sd5,   1'b0);

    start_phase(1'b1, 1'b1, 9, 52);
    queue_cmd(ACT_SET,    KIND_MOTOR, 4'd0,  16'sd16384, 1'b0);
    queue_cmd(ACT_ENABLE, KIND_MOTOR, 4'd0,  16'sd0,     1'b1);
    queue_cmd(ACT_SET,    KIND_MOTOR, 4'd0,  16'sh7FFF,  1'b0);
    queue_cmd(ACT_ENABLE, KIND_MOTOR, 4'd1,  16'sd0,     1'b1);
    queue_cmd(ACT_SET,    KIND_MOTOR, 4'd1,  16'sh8000,  1'b0);
    queue_cmd(ACT_ADD,    KIND_MOTOR, 4'd1,  16'sh8000,  1'b0);
    queue_cmd(ACT_ENABLE, KIND_MOTOR, 4'd3,  16'sh7FFF,  1'b1);
    queue_cmd(ACT_ADD,    KIND_MOTOR, 4'd3,  16'sd1,     1'b0);
    queue_cmd(ACT_SET,    KIND_MOTOR, 4'd3,  16'sd0,     1'b1);
    queue_cmd(ACT_SET,    KIND_MOTOR, 4'd4,  16'sd100,   1'b1);
    queue_cmd(ACT_ENABLE, KIND_MOTOR, 4'd15, 16'sh7FFF,  1'b1);
    queue_cmd(ACT_SET,    KIND_SERVO, 4'd0,  16'sd16384, 1'b0);
    queue_cmd(ACT_ENABLE, KIND_SERVO, 4'd0,  16'sd0,     1'b1);
    queue_cmd(ACT_ENABLE, KIND_SERVO, 4'd7,  16'sd0,     1'b1);
    queue_cmd(ACT_SET,    KIND_SERVO, 4'd7,  16'sh7FFF,  1'b0);
    queue_cmd(ACT_ADD,    KIND_SERVO, 4'd7,  16'sh8000,  1'b0);
    queue_cmd(ACT_ENABLE, KIND_SERVO, 4'd4,  16'sd0,     1'b1);
    queue_cmd(ACT_ADD,    KIND_SERVO, 4'd4,  16'sd100,   1'b0);
    queue_cmd(ACT_SET,    KIND_SERVO, 4'd8,  16'sd100,   1'b1);
    queue_cmd(ACT_ADD,    KIND_SERVO, 4'd15, 16'sh7FFF,  1'b1);
    queue_cmd(ACT_NONE,   KIND_MOTOR, 4'd0,  16'sh7FFF,  1'b1);
    queue_cmd(ACT_NONE,   KIND_SERVO, 4'd15, 16'sh8000,  1'b1);

    start_phase(1'b1, 1'b1, 9, 52);
    run_random(250, 1'b1);
    start_phase(1'b1, 1'b0, 9, 52);
    run_random(40, 1'b0);
    start_phase(1'b1, 1'b1, 52, 9);
    run_random(200, 1'b0);
    start_phase(1'b1, 1'b0, 52, 9);
    run_random(40, 1'b0);
    start_phase(1'b1, 1'b1, 0, 0);
    run_random(120, 1'b0);

    wait_quiet();
    repeat (SETTLE_CYCLES * 3) @(negedge clk);
    if (expected_writes.size() != 0) errors++;
    $display("Checked %0d commands and %0d results with the PWM device present and absent,",
             n_accepted, n_results);
    $display("under sender and receiver idling, and %0d mismatches were found.", errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
src/mspsc_pkg.sv
src/mspsc_front.sv
src/mspsc_queue.sv
src/mspsc_back.sv
src/motor_servo_pwm_setpoint_ctrl_unit.sv
tb/motor_servo_pwm_setpoint_ctrl_unit_tb.sv
